### hw/rtl/rgb_to_hsv_convert_top_assert.svh
// Assertion macros for the RGB to HSV converter.
// Included by the top level; needs the clock and reset names of that module.
`ifndef RGB_TO_HSV_CONVERT_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgb_to_hsv_convert: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgb_to_hsv_convert: next-cycle check failed");

`endif

### hw/rtl/rhc_pkg.sv
// Shared types, constants and helper functions of the RGB to HSV converter.
// Used by every module of the block; depends on nothing.
package rhc_pkg;

   localparam int CHAN_W = 8;
   localparam int HUE_W = 15;
   localparam int QUOT_W = 12;
   localparam int REM_W = 20;

   localparam int CHAN_FULL = 255;
   localparam int HUE_SIXTH = 3840;
   localparam int HUE_FULL = 23040;
   localparam int HUE_BASE_GREEN = 7680;
   localparam int HUE_BASE_BLUE = 15360;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [REM_W-1:0]  hue_rem;
      logic [REM_W-1:0]  sat_rem;
      logic [CHAN_W-1:0] delta;
      logic [CHAN_W-1:0] mx;
      logic [QUOT_W-1:0] hue_q;
      logic [QUOT_W-1:0] sat_q;
      sector_type        sector;
      logic              neg;
      logic              hue_zero;
      logic              sat_zero;
      logic [CHAN_W-1:0] bright;
   } div_type;

   function automatic logic [HUE_W-1:0] sector_base(input sector_type sector);
      logic [HUE_W-1:0] base;
      case (sector)
         SECTOR_RED: begin
            base = '0;
         end
         SECTOR_GREEN: begin
            base = HUE_W'(HUE_BASE_GREEN);
         end
         SECTOR_BLUE: begin
            base = HUE_W'(HUE_BASE_BLUE);
         end
         default: begin
            base = '0;
         end
      endcase
      return base;
   endfunction

endpackage

### hw/rtl/rhc_prep.sv
// Front stage: finds max, min and sector of a pixel and forms both dividends.
// Depends on rhc_pkg.
module rhc_prep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mode,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [rhc_pkg::CHAN_W-1:0] red,
   input  logic [rhc_pkg::CHAN_W-1:0] green,
   input  logic [rhc_pkg::CHAN_W-1:0] blue,
   output logic                       out_valid,
   input  logic                       out_ready,
   output rhc_pkg::div_type           out_data
);

   logic                      valid_ff;
   rhc_pkg::div_type          data_ff;
   rhc_pkg::div_type          data_in;
   logic [rhc_pkg::CHAN_W-1:0] mx;
   logic [rhc_pkg::CHAN_W-1:0] mn;
   logic [rhc_pkg::CHAN_W-1:0] op_a;
   logic [rhc_pkg::CHAN_W-1:0] op_b;
   logic [rhc_pkg::CHAN_W-1:0] mag;
   rhc_pkg::sector_type        sector;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_comb begin
      mx = red;
      if (green > mx) begin
         mx = green;
      end
      if (blue > mx) begin
         mx = blue;
      end
      mn = red;
      if (green < mn) begin
         mn = green;
      end
      if (blue < mn) begin
         mn = blue;
      end

      if (red == mx) begin
         sector = rhc_pkg::SECTOR_RED;
         op_a = green;
         op_b = blue;
      end else if (green == mx) begin
         sector = rhc_pkg::SECTOR_GREEN;
         op_a = blue;
         op_b = red;
      end else begin
         sector = rhc_pkg::SECTOR_BLUE;
         op_a = red;
         op_b = green;
      end
      mag = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

      data_in.delta = mx - mn;
      data_in.mx = mx;
      data_in.hue_rem = rhc_pkg::REM_W'(mag) * rhc_pkg::REM_W'(rhc_pkg::HUE_SIXTH);
      data_in.sat_rem = rhc_pkg::REM_W'(mx - mn) * rhc_pkg::REM_W'(rhc_pkg::CHAN_FULL);
      data_in.hue_q = '0;
      data_in.sat_q = '0;
      data_in.sector = sector;
      data_in.neg = op_a < op_b;
      data_in.hue_zero = !mode || (mx == mn);
      data_in.sat_zero = !mode || (mx == '0);
      data_in.bright = mode ? mx : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hw/rtl/rhc_div_cell.sv
// One cell of the divider chain: resolves one quotient bit of both divisions.
// Depends on rhc_pkg.
module rhc_div_cell #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rhc_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rhc_pkg::div_type out_data
);

   logic                      valid_ff;
   rhc_pkg::div_type          data_ff;
   rhc_pkg::div_type          data_in;
   logic [rhc_pkg::REM_W-1:0] hue_div;
   logic [rhc_pkg::REM_W-1:0] sat_div;
   logic [rhc_pkg::QUOT_W-1:0] q_bit;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   assign hue_div = rhc_pkg::REM_W'(in_data.delta) << SHIFT;
   assign sat_div = rhc_pkg::REM_W'(in_data.mx) << SHIFT;
   assign q_bit = rhc_pkg::QUOT_W'(1) << SHIFT;

   always_comb begin
      data_in = in_data;
      if (in_data.hue_rem >= hue_div) begin
         data_in.hue_rem = in_data.hue_rem - hue_div;
         data_in.hue_q = in_data.hue_q | q_bit;
      end
      if (in_data.sat_rem >= sat_div) begin
         data_in.sat_rem = in_data.sat_rem - sat_div;
         data_in.sat_q = in_data.sat_q | q_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hw/rtl/rhc_finish.sv
// Output stage: applies sector base, sign and wrap, and holds the result item.
// Depends on rhc_pkg.
module rhc_finish (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  rhc_pkg::div_type           in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [rhc_pkg::HUE_W-1:0]  hue,
   output logic [rhc_pkg::CHAN_W-1:0] saturation,
   output logic [rhc_pkg::CHAN_W-1:0] brightness
);

   logic                       valid_ff;
   logic [rhc_pkg::HUE_W-1:0]  hue_ff;
   logic [rhc_pkg::HUE_W-1:0]  hue_in;
   logic [rhc_pkg::CHAN_W-1:0] sat_ff;
   logic [rhc_pkg::CHAN_W-1:0] sat_in;
   logic [rhc_pkg::CHAN_W-1:0] bright_ff;
   logic [rhc_pkg::HUE_W-1:0]  base;
   logic [rhc_pkg::HUE_W-1:0]  frac;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign hue = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;

   assign base = rhc_pkg::sector_base(in_data.sector);
   assign frac = rhc_pkg::HUE_W'(in_data.hue_q);

   always_comb begin
      if (in_data.hue_zero) begin
         hue_in = '0;
      end else if (!in_data.neg || (frac == '0)) begin
         hue_in = base + frac;
      end else if (base == '0) begin
         hue_in = rhc_pkg::HUE_W'(rhc_pkg::HUE_FULL) - frac;
      end else begin
         hue_in = base - frac;
      end
      sat_in = in_data.sat_zero ? '0 : in_data.sat_q[rhc_pkg::CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bright_ff <= in_data.bright;
      end
   end

endmodule

### hw/rtl/rgb_to_hsv_convert_top.sv
// Top level of the RGB to HSV converter: mode register and the stage chain.
// Depends on rhc_pkg, rhc_prep, rhc_div_cell, rhc_finish and the assert header.
//
// Usage: an input item (req_red, req_green, req_blue) is taken at a clock edge
// where req_valid is high and req_stall is low. Each item gives exactly one
// result item on rsp_hue, rsp_saturation and rsp_brightness, delivered at an
// edge where rsp_valid is high and rsp_stall is low. Results leave in order.
// From acceptance to rsp_valid an item passes through one front
// stage, a chain of 12 divider cells that each settle one quotient bit of the
// hue and saturation divisions, and one output register.
// Throughput is one item per clock while rsp_stall is low; every stage holds its own item.
// When the receiver stalls, the output register holds its item and the stages
// behind it keep filling until the chain is full; only then is req_stall
// raised. csr_write_en writes csr_write_data into the color mode register;
// write it only while no item is in flight.
// Synchronous reset empties every stage and sets the color mode to 1.
`include "rgb_to_hsv_convert_top_assert.svh"

module rgb_to_hsv_convert_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic                       csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rhc_pkg::CHAN_W-1:0] req_red,
   input  logic [rhc_pkg::CHAN_W-1:0] req_green,
   input  logic [rhc_pkg::CHAN_W-1:0] req_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rhc_pkg::HUE_W-1:0]  rsp_hue,
   output logic [rhc_pkg::CHAN_W-1:0] rsp_saturation,
   output logic [rhc_pkg::CHAN_W-1:0] rsp_brightness
);

   localparam int NumCells = rhc_pkg::QUOT_W;

   logic             mode_ff;
   logic             prep_ready;
   logic             chain_valid [NumCells+1];
   logic             chain_ready [NumCells+1];
   rhc_pkg::div_type chain_data  [NumCells+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   assign req_stall = !prep_ready;

   rhc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_valid),
      .in_ready  (prep_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      rhc_div_cell #(
         .SHIFT (NumCells - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   rhc_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[NumCells]),
      .in_ready   (chain_ready[NumCells]),
      .in_data    (chain_data[NumCells]),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .brightness (rsp_brightness)
   );

   `RHC_ASSERT_IMPLY(a_hue_range, rsp_valid, rsp_hue < rhc_pkg::HUE_W'(rhc_pkg::HUE_FULL))
   `RHC_ASSERT_IMPLY(a_black_pixel, rsp_valid && (rsp_brightness == '0), (rsp_saturation == '0) && (rsp_hue == '0))
   `RHC_ASSERT_IMPLY(a_gray_pixel, rsp_valid && (rsp_saturation == '0), rsp_hue == '0)
   `RHC_ASSERT_NEXT(a_mode_off, !mode_ff && !csr_write_en && chain_valid[NumCells] && chain_ready[NumCells], rsp_valid && (rsp_brightness == '0))

endmodule

### dv/rgb_to_hsv_convert_top_tb.sv
// Self-checking testbench for the RGB to HSV converter top level.
// Drives pixels with random gaps and stalls and compares every HSV item with
// its own fixed-point prediction; depends on rhc_pkg and rgb_to_hsv_convert_top.
module rgb_to_hsv_convert_top_tb;

   localparam int CHAN_W = rhc_pkg::CHAN_W;
   localparam int HUE_W = rhc_pkg::HUE_W;
   localparam int PIXEL_W = 3 * CHAN_W;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD = 150;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic              csr_write_data = 1'b0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CHAN_W-1:0] req_red = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [HUE_W-1:0]  rsp_hue;
   logic [CHAN_W-1:0] rsp_saturation;
   logic [CHAN_W-1:0] rsp_brightness;

   pixel_type pixel_q[$];
   hsv_type   hsv_expect_q[$];
   logic      mode_model = 1'b1;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        send_gap = 0;
   int        recv_gap = 0;
   int        hold_cnt = 0;
   int        result_cnt = 0;
   int        mismatch_cnt = 0;
   int        cycle_cnt = 0;

   rgb_to_hsv_convert_top uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic hsv_type convert_pixel(input pixel_type px, input logic three_chan);
      int                  r, g, b, mx, mn, delta, diff, hue_v, base;
      rhc_pkg::sector_type sector;
      hsv_type             res;
      res = '0;
      if (three_chan) begin
         r = px.red;
         g = px.green;
         b = px.blue;
         mx = (r > g) ? r : g;
         mx = (b > mx) ? b : mx;
         mn = (r < g) ? r : g;
         mn = (b < mn) ? b : mn;
         delta = mx - mn;
         hue_v = 0;
         if (mx != 0) begin
            res.saturation = CHAN_W'((rhc_pkg::CHAN_FULL * delta) / mx);
            if (delta != 0) begin
               if (r == mx) begin
                  sector = rhc_pkg::SECTOR_RED;
               end else if (g == mx) begin
                  sector = rhc_pkg::SECTOR_GREEN;
               end else begin
                  sector = rhc_pkg::SECTOR_BLUE;
               end
               case (sector)
                  rhc_pkg::SECTOR_RED: begin
                     base = 0;
                     diff = g - b;
                  end
                  rhc_pkg::SECTOR_GREEN: begin
                     base = rhc_pkg::HUE_BASE_GREEN;
                     diff = b - r;
                  end
                  default: begin
                     base = rhc_pkg::HUE_BASE_BLUE;
                     diff = r - g;
                  end
               endcase
               // Signed integer division truncates toward zero.
               hue_v = base + (rhc_pkg::HUE_SIXTH * diff) / delta;
               if (hue_v < 0) begin
                  hue_v += rhc_pkg::HUE_FULL;
               end
            end
         end
         res.hue = HUE_W'(hue_v);
         res.brightness = CHAN_W'(mx);
      end
      return res;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int        v;
      px = pixel_type'(PIXEL_W'($urandom));
      case ($urandom_range(0, 9))
         0: begin
            v = $urandom_range(0, 255);
            px = '{CHAN_W'(v), CHAN_W'(v), CHAN_W'(v)};
         end
         1: begin
            v = $urandom_range(1, 255);
            case ($urandom_range(0, 2))
               0: px = '{CHAN_W'(v), CHAN_W'(v), CHAN_W'($urandom_range(0, v))};
               1: px = '{CHAN_W'($urandom_range(0, v)), CHAN_W'(v), CHAN_W'(v)};
               default: px = '{CHAN_W'(v), CHAN_W'($urandom_range(0, v)), CHAN_W'(v)};
            endcase
         end
         2: begin
            px = '{CHAN_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 3)),
                   CHAN_W'($urandom_range(0, 3))};
         end
         3: begin
            px.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
            px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
            px.blue = $urandom_range(0, 1) ? 8'hff : CHAN_W'($urandom);
         end
         4: begin
            px.green = px.red ^ CHAN_W'($urandom_range(0, 3));
            px.blue = px.red ^ CHAN_W'($urandom_range(0, 3));
         end
         default: begin
         end
      endcase
      return px;
   endfunction

   // Sender: holds a stalled item steady and draws new ones from the queue.
   always @(posedge clock) begin
      logic      nxt_valid;
      pixel_type nxt_px;
      nxt_valid = req_valid;
      nxt_px = '{req_red, req_green, req_blue};
      if (reset) begin
         nxt_valid = 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            hsv_expect_q.insert(hsv_expect_q.size(), convert_pixel(nxt_px, mode_model));
            nxt_valid = 1'b0;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if ($urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(0, 12);
            end else if (pixel_q.size() != 0) begin
               nxt_px = pixel_q.pop_front();
               nxt_valid = 1'b1;
            end
         end
      end
      req_valid <= nxt_valid;
      req_red <= nxt_px.red;
      req_green <= nxt_px.green;
      req_blue <= nxt_px.blue;
   end

   // Receiver: checks each accepted item and decides the next stall.
   always @(posedge clock) begin
      logic    nxt_stall;
      hsv_type want;
      nxt_stall = 1'b0;
      if (reset) begin
         recv_gap = 0;
         hold_cnt = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_cnt++;
            if (hsv_expect_q.size() == 0) begin
               $error("unexpected item: hue %0d saturation %0d brightness %0d",
                      rsp_hue, rsp_saturation, rsp_brightness);
               mismatch_cnt++;
            end else begin
               want = hsv_expect_q.pop_front();
               if (rsp_hue !== want.hue) begin
                  $error("hue: expected %0d, actual %0d", want.hue, rsp_hue);
                  mismatch_cnt++;
               end
               if (rsp_saturation !== want.saturation) begin
                  $error("saturation: expected %0d, actual %0d",
                         want.saturation, rsp_saturation);
                  mismatch_cnt++;
               end
               if (rsp_brightness !== want.brightness) begin
                  $error("brightness: expected %0d, actual %0d",
                         want.brightness, rsp_brightness);
                  mismatch_cnt++;
               end
            end
            // Hold off long enough for the whole chain to back up.
            if (result_cnt == 300 || result_cnt == 1000) begin
               hold_cnt = LONG_HOLD;
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            nxt_stall = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            nxt_stall = 1'b1;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap = $urandom_range(0, 12);
            nxt_stall = 1'b1;
         end
      end
      rsp_stall <= nxt_stall;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_mode(input logic value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      mode_model = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic add_pixel(input int r, input int g, input int b);
      pixel_q.insert(pixel_q.size(), '{CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)});
   endtask

   task automatic add_random(input int count);
      repeat (count) pixel_q.insert(pixel_q.size(), random_pixel());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pixel_q.size() != 0 || req_valid || hsv_expect_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b1);
      send_idle_pct = 20;
      recv_idle_pct = 20;
      add_pixel(0, 0, 0);
      add_pixel(255, 255, 255);
      add_pixel(128, 128, 128);
      add_pixel(255, 0, 0);
      add_pixel(0, 255, 0);
      add_pixel(0, 0, 255);
      add_pixel(255, 0, 1);
      add_pixel(255, 255, 0);
      add_pixel(0, 255, 255);
      add_pixel(255, 0, 255);
      add_pixel(1, 0, 0);
      add_pixel(0, 0, 1);
      add_pixel(1, 2, 3);
      add_pixel(200, 100, 50);
      add_pixel(255, 254, 0);
      add_pixel(3, 1, 2);
      add_pixel(85, 170, 255);
      add_pixel(170, 0, 85);
      wait_drained();

      write_mode(1'b0);
      add_pixel(255, 255, 255);
      add_pixel(255, 0, 1);
      add_pixel(1, 2, 3);
      add_pixel(0, 0, 0);
      add_random(100);
      wait_drained();

      // The long receiver hold-off falls in this phase and in the fifth one.
      write_mode(1'b1);
      send_idle_pct = 30;
      recv_idle_pct = 30;
      add_random(700);
      wait_drained();

      write_mode(1'b0);
      send_idle_pct = 10;
      recv_idle_pct = 40;
      add_random(100);
      wait_drained();

      write_mode(1'b1);
      send_idle_pct = 10;
      recv_idle_pct = 10;
      add_random(500);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(400);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && hsv_expect_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
